// File: design/sfce_pkg.sv
// Shared types and constants of the SPI flash command engine.
package sfce_pkg;

  // Default width of an image byte address.
  localparam int unsigned AddrBitsDef = 18;

  // Flash command opcodes.
  localparam logic [7:0] OpRead      = 8'h03;
  localparam logic [7:0] OpReadStat  = 8'h05;
  localparam logic [7:0] OpWrite     = 8'h0A;
  localparam logic [7:0] OpReadId    = 8'h9F;
  localparam logic [7:0] OpWrDisable = 8'h04;
  localparam logic [7:0] OpWrEnable  = 8'h06;
  localparam logic [7:0] OpProgram   = 8'h02;

  // Identification bytes and the idle answer.
  localparam logic [7:0] IdByte0     = 8'h20;
  localparam logic [7:0] IdByte1     = 8'h40;
  localparam logic [7:0] IdByte2     = 8'h12;
  localparam logic [7:0] RespIdle    = 8'hFF;

  // Byte position at which the data phase begins; the counter stops there.
  localparam logic [2:0] PosData     = 3'd4;

  // Kind of an input beat.
  typedef enum logic [1:0] {
    KIND_SPI     = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_LOAD    = 2'd2
  } kind_e;

  // How the response register is updated once the memory has answered.
  typedef enum logic [1:0] {
    RESP_KEEP = 2'd0,
    RESP_SET  = 2'd1,
    RESP_MEM  = 2'd2
  } resp_sel_e;

  // Control carried from the memory access stage to the result stage.
  typedef struct packed {
    resp_sel_e  resp_sel;
    logic [7:0] value;
    logic       wel;
    logic       flush;
  } stage_t;

endpackage

// File: design/sfce_in_if.sv
// Input channel of the SPI flash command engine.
interface sfce_in_if #(
  parameter int unsigned AddrBits = 18
);
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [7:0]          tx_byte;
  logic [AddrBits-1:0] load_address;

  modport source (output valid, command, tx_byte, load_address, input ready);
  modport sink (input valid, command, tx_byte, load_address, output ready);
endinterface

// File: design/sfce_out_if.sv
// Result channel of the SPI flash command engine.
interface sfce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       write_enabled;
  logic       flush_request;

  modport source (output valid, rx_byte, write_enabled, flush_request, input ready);
  modport sink (input valid, rx_byte, write_enabled, flush_request, output ready);
endinterface

// File: design/spi_flash_command_engine_unit.sv
// Top level of the SPI flash command engine: command decode, image memory and result stage.

// The engine accepts one beat per clock cycle while its output is not stalled
// (an SPI byte, a chip-select release or a backdoor image load) and delivers
// exactly one result beat for each. The image memory read and the middle stage
// load at the edge that accepts the input beat. The output register loads from
// the middle stage once it is empty or its beat is taken, and the result beat
// is offered from then on. The single-port-read, single-port-write image
// memory of 2^AddrBits bytes is touched at most once per beat, which sets the
// rate of one beat per cycle. Image bytes hold no defined value until loaded
// or written, and reading an unwritten byte returns an arbitrary value. Input
// backpressure follows the output: the input is held off only while both the
// middle stage and the output register are full and the output beat is not
// taken.
module spi_flash_command_engine_unit import sfce_pkg::*; #(
  parameter int unsigned AddrBits = AddrBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfce_in_if.sink      in_i,
  sfce_out_if.source   out_o
);

  localparam int unsigned MemDepth = 1 << AddrBits;

  // Command state.
  logic                sel_q, sel_d;
  logic [7:0]          cmd_q, cmd_d;
  logic [2:0]          pos_q, pos_d;
  logic [AddrBits-1:0] addr_q, addr_d;
  logic                wel_q, wel_d;

  // Memory port signals.
  logic                mem_we, mem_re;
  logic [AddrBits-1:0] mem_waddr;
  logic [7:0]          mem_wdata;
  logic [7:0]          mem_q [MemDepth];
  logic [7:0]          rdata_q;

  // Pipeline and output registers.
  logic                p1_valid_q;
  stage_t              p1_q, p1_d;
  logic                out_valid_q;
  logic [7:0]          resp_q;
  logic                wel_out_q, flush_out_q;
  logic                accept, p1_adv;
  kind_e               kind;
  logic [7:0]          tx;

  assign kind   = kind_e'(in_i.command);
  assign tx     = in_i.tx_byte;
  assign p1_adv = p1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !p1_valid_q || p1_adv;
  assign accept = in_i.valid && in_i.ready;

  // Decode the accepted beat: next command state, memory access and response update.
  always_comb begin
    sel_d     = sel_q;
    cmd_d     = cmd_q;
    pos_d     = pos_q;
    addr_d    = addr_q;
    wel_d     = wel_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = tx;
    p1_d.resp_sel = RESP_KEEP;
    p1_d.value    = 8'h00;
    p1_d.flush    = 1'b0;
    if (accept) begin
      unique case (kind)
        KIND_SPI: begin
          if (!sel_q) begin
            // The first byte after select is the command.
            sel_d  = 1'b1;
            cmd_d  = tx;
            pos_d  = 3'd1;
            addr_d = '0;
            p1_d.resp_sel = RESP_SET;
            if (tx == OpWrDisable) begin
              wel_d = 1'b0;
            end else if (tx == OpWrEnable) begin
              wel_d = 1'b1;
            end
          end else begin
            unique case (cmd_q)
              OpRead, OpWrite: begin
                p1_d.resp_sel = RESP_SET;
                if (pos_q < PosData) begin
                  addr_d = {addr_q[AddrBits-9:0], tx};
                  pos_d  = pos_q + 3'd1;
                end else begin
                  if (cmd_q == OpRead) begin
                    mem_re        = 1'b1;
                    p1_d.resp_sel = RESP_MEM;
                  end else begin
                    mem_we     = 1'b1;
                    p1_d.value = tx;
                  end
                  addr_d = addr_q + AddrBits'(1);
                end
              end
              OpReadStat: begin
                p1_d.resp_sel = RESP_SET;
                p1_d.value    = {6'b0, wel_q, 1'b0};
              end
              OpReadId: begin
                p1_d.resp_sel = RESP_SET;
                unique case (pos_q)
                  3'd1:    p1_d.value = IdByte0;
                  3'd2:    p1_d.value = IdByte1;
                  3'd3:    p1_d.value = IdByte2;
                  default: p1_d.value = 8'h00;
                endcase
                if (pos_q < PosData) begin
                  pos_d = pos_q + 3'd1;
                end
              end
              default: begin
                p1_d.resp_sel = RESP_SET;
                p1_d.value    = RespIdle;
              end
            endcase
          end
        end
        KIND_RELEASE: begin
          p1_d.flush = (cmd_q == OpProgram) || (cmd_q == OpWrite);
          sel_d = 1'b0;
          cmd_d = 8'h00;
          pos_d = '0;
        end
        KIND_LOAD: begin
          mem_we    = 1'b1;
          mem_waddr = in_i.load_address;
        end
        default: begin
          // The unused kind code leaves everything as it is.
        end
      endcase
    end
    p1_d.wel = wel_d;
  end

  // Command state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q  <= 1'b0;
      cmd_q  <= 8'h00;
      pos_q  <= '0;
      addr_q <= '0;
      wel_q  <= 1'b0;
    end else begin
      sel_q  <= sel_d;
      cmd_q  <= cmd_d;
      pos_q  <= pos_d;
      addr_q <= addr_d;
      wel_q  <= wel_d;
    end
  end

  // Image memory with a registered read port; accesses are in beat order.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[addr_q];
    end
  end

  // Stage after the memory access.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (accept) begin
      p1_valid_q <= 1'b1;
    end else if (p1_adv) begin
      p1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_q <= p1_d;
    end
  end

  // Output register; the response register keeps its value between beats.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      resp_q      <= 8'h00;
      wel_out_q   <= 1'b0;
      flush_out_q <= 1'b0;
    end else begin
      if (p1_adv) begin
        out_valid_q <= 1'b1;
        wel_out_q   <= p1_q.wel;
        flush_out_q <= p1_q.flush;
        unique case (p1_q.resp_sel)
          RESP_SET: resp_q <= p1_q.value;
          RESP_MEM: resp_q <= rdata_q;
          default:  resp_q <= resp_q;
        endcase
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.rx_byte       = resp_q;
  assign out_o.write_enabled = wel_out_q;
  assign out_o.flush_request = flush_out_q;

  // A held middle stage must stall the input.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_valid_q && !p1_adv |-> !in_i.ready)
    else $error("input accepted while the middle stage is stalled");

  // Only a release can request a flush.
  a_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && kind != KIND_RELEASE |=> !p1_q.flush)
    else $error("flush request from a beat that is not a release");

  // The byte position is zero whenever the device is deselected and never passes the data phase.
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!sel_q |-> pos_q == 3'd0) and (pos_q <= PosData))
    else $error("byte position inconsistent with select state");

  // A memory read is followed by a stage that takes its data.
  a_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |=> p1_valid_q && p1_q.resp_sel == RESP_MEM)
    else $error("memory read data not claimed by the next stage");

endmodule

// File: verif/sfce_flash_checker.sv
// Result checker of the SPI flash command engine: predicts every result beat and compares it.
module sfce_flash_checker import sfce_pkg::*; #(
  parameter int unsigned AddrBits = AddrBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [1:0]          in_command_i,
  input  logic [7:0]          in_tx_byte_i,
  input  logic [AddrBits-1:0] in_load_address_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [7:0]          out_rx_byte_i,
  input  logic                out_write_enabled_i,
  input  logic                out_flush_request_i,
  output int                  err_count_o,
  output int                  pending_o
);

  // Write-enable latch within the status byte.
  localparam logic [7:0] WelMask = 8'h02;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       wel;
    logic       flush;
  } flash_resp_t;

  // Shadow copy of the flash state and of the image memory.
  logic                sel_q;
  logic [7:0]          cmd_q;
  logic [2:0]          pos_q;
  logic [AddrBits-1:0] addr_q;
  logic [7:0]          resp_q;
  logic [7:0]          status_q;
  logic [7:0]          image_mem [0:(1 << AddrBits) - 1];

  flash_resp_t expected_resp[$];
  int          errs = 0;

  assign err_count_o = errs;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errs++;
  endtask

  // Advances the shadow state by one accepted input beat and queues the result it causes.
  task automatic predict_flash_beat(input logic [1:0] kind, input logic [7:0] v,
                                    input logic [AddrBits-1:0] la);
    logic        flush;
    flash_resp_t r;
    flush = 1'b0;
    if (kind == KIND_SPI) begin
      if (!sel_q) begin
        // The first byte after select is latched as the command.
        cmd_q  = v;
        sel_q  = 1'b1;
        resp_q = 8'h00;
        pos_q  = 3'd1;
        addr_q = '0;
        if (v == OpWrDisable) begin
          status_q = status_q & ~WelMask;
        end else if (v == OpWrEnable) begin
          status_q = status_q | WelMask;
        end
      end else begin
        case (cmd_q)
          OpRead, OpWrite: begin
            if (pos_q < PosData) begin
              addr_q = (addr_q << 8) | AddrBits'(v);
              resp_q = 8'h00;
            end else begin
              if (cmd_q == OpRead) begin
                resp_q = image_mem[addr_q];
              end else begin
                image_mem[addr_q] = v;
                resp_q = v;
              end
              addr_q = addr_q + AddrBits'(1);
            end
            if (pos_q < PosData) pos_q = pos_q + 3'd1;
          end
          OpReadStat: begin
            resp_q = status_q;
          end
          OpReadId: begin
            case (pos_q)
              3'd1:    resp_q = IdByte0;
              3'd2:    resp_q = IdByte1;
              3'd3:    resp_q = IdByte2;
              default: resp_q = 8'h00;
            endcase
            if (pos_q < PosData) pos_q = pos_q + 3'd1;
          end
          default: begin
            resp_q = RespIdle;
          end
        endcase
      end
    end else if (kind == KIND_RELEASE) begin
      // A release ends the command; program and write commands ask for a flush.
      flush = (cmd_q == OpProgram) || (cmd_q == OpWrite);
      sel_q = 1'b0;
      cmd_q = 8'h00;
      pos_q = 3'd0;
    end else if (kind == KIND_LOAD) begin
      image_mem[la] = v;
    end
    r.rx_byte = resp_q;
    r.wel     = |(status_q & WelMask);
    r.flush   = flush;
    expected_resp.push_back(r);
  endtask

  // Compare each result beat with the oldest prediction, then predict from the input beat.
  always @(posedge clk_i or negedge rst_ni) begin
    flash_resp_t want;
    if (!rst_ni) begin
      sel_q    = 1'b0;
      cmd_q    = 8'h00;
      pos_q    = 3'd0;
      addr_q   = '0;
      resp_q   = 8'h00;
      status_q = 8'h00;
      expected_resp.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_resp.size() == 0) begin
          report_mismatch($sformatf("result beat rx_byte 0x%02h with nothing expected",
                                    out_rx_byte_i));
        end else begin
          want = expected_resp.pop_front();
          if (out_rx_byte_i !== want.rx_byte) begin
            report_mismatch($sformatf("rx_byte 0x%02h, expected 0x%02h",
                                      out_rx_byte_i, want.rx_byte));
          end
          if (out_write_enabled_i !== want.wel) begin
            report_mismatch($sformatf("write_enabled %b, expected %b",
                                      out_write_enabled_i, want.wel));
          end
          if (out_flush_request_i !== want.flush) begin
            report_mismatch($sformatf("flush_request %b, expected %b",
                                      out_flush_request_i, want.flush));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_flash_beat(in_command_i, in_tx_byte_i, in_load_address_i);
      end
      pending_o <= expected_resp.size();
    end
  end

endmodule

// File: verif/tb.sv
// Testbench top of the SPI flash command engine: clock, reset, stimulus and verdict.
module tb;
  import sfce_pkg::*;

  localparam int unsigned AW = AddrBitsDef;

  // The input kind that the engine ignores.
  localparam logic [1:0] KindIgnored = 2'd3;

  localparam int BeatTarget  = 1900;
  localparam int QuietFrom   = 500;
  localparam int QuietTo     = 800;
  localparam int HoldAt      = 1100;
  localparam int HoldCycles  = 400;
  localparam int PauseAt     = 1500;
  localparam int DrainCycles = 10;
  localparam int TimeLimit   = 4000000;

  logic clk_i;
  logic rst_ni;

  sfce_in_if #(.AddrBits(AW)) in_ch ();
  sfce_out_if                 out_ch ();

  int err_count;
  int pending;
  int beats_sent;
  bit paused;

  // Stimulus-side view of the command state, so that no unwritten image byte is ever read.
  bit              written_map [0:(1 << AW) - 1];
  logic            trk_sel;
  logic [7:0]      trk_cmd;
  logic [2:0]      trk_pos;
  logic [AW-1:0]   trk_addr;

  spi_flash_command_engine_unit #(.AddrBits(AW)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  sfce_flash_checker #(.AddrBits(AW)) u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_ch.valid),
    .in_ready_i          (in_ch.ready),
    .in_command_i        (in_ch.command),
    .in_tx_byte_i        (in_ch.tx_byte),
    .in_load_address_i   (in_ch.load_address),
    .out_valid_i         (out_ch.valid),
    .out_ready_i         (out_ch.ready),
    .out_rx_byte_i       (out_ch.rx_byte),
    .out_write_enabled_i (out_ch.write_enabled),
    .out_flush_request_i (out_ch.flush_request),
    .err_count_o         (err_count),
    .pending_o           (pending)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #(TimeLimit);
    $display("Some tests failed");
    $finish;
  end

  // Neither side idles within this window of beats.
  function automatic bit quiet_window();
    return (beats_sent >= QuietFrom) && (beats_sent < QuietTo);
  endfunction

  // Offers one beat, after an optional random gap, and waits until it is accepted.
  task automatic send_beat(input logic [1:0] k, input logic [7:0] b, input logic [AW-1:0] a);
    if (!quiet_window()) begin
      while ($urandom_range(0, 99) < 15) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= k;
    in_ch.tx_byte      <= b;
    in_ch.load_address <= (k == KIND_LOAD) ? a : AW'($urandom);
    do @(posedge clk_i); while (!in_ch.ready);
    beats_sent++;
  endtask

  // Sends a beat and follows the command state; a data read of an unwritten byte is
  // preceded by a load of that byte.
  task automatic put_beat(input logic [1:0] k, input logic [7:0] b, input logic [AW-1:0] a);
    if (k == KIND_SPI && trk_sel && trk_cmd == OpRead && trk_pos >= PosData &&
        !written_map[trk_addr]) begin
      send_beat(KIND_LOAD, 8'($urandom), trk_addr);
      written_map[trk_addr] = 1'b1;
    end
    send_beat(k, b, a);
    if (k == KIND_SPI) begin
      if (!trk_sel) begin
        trk_sel  = 1'b1;
        trk_cmd  = b;
        trk_pos  = 3'd1;
        trk_addr = '0;
      end else if (trk_cmd == OpRead || trk_cmd == OpWrite) begin
        if (trk_pos < PosData) begin
          trk_addr = (trk_addr << 8) | AW'(b);
          trk_pos  = trk_pos + 3'd1;
        end else begin
          if (trk_cmd == OpWrite) written_map[trk_addr] = 1'b1;
          trk_addr = trk_addr + AW'(1);
        end
      end else if (trk_cmd == OpReadId && trk_pos < PosData) begin
        trk_pos = trk_pos + 3'd1;
      end
    end else if (k == KIND_RELEASE) begin
      trk_sel = 1'b0;
      trk_cmd = 8'h00;
      trk_pos = 3'd0;
    end else if (k == KIND_LOAD) begin
      written_map[a] = 1'b1;
    end
  endtask

  task automatic spi(input logic [7:0] b);
    put_beat(KIND_SPI, b, '0);
  endtask

  task automatic cs_release();
    put_beat(KIND_RELEASE, 8'($urandom), '0);
  endtask

  // Three address bytes, most significant first; the top bits fall off the counter.
  task automatic send_address(input logic [23:0] a);
    spi(a[23:16]);
    spi(a[15:8]);
    spi(a[7:0]);
  endtask

  // Addresses cluster at the top of memory and at the bottom, so that reads meet writes.
  function automatic logic [23:0] pick_address();
    logic [23:0] a;
    int          r;
    a = 24'($urandom);
    r = $urandom_range(0, 99);
    if (r < 25) begin
      a[AW-1:0] = AW'((1 << AW) - 1 - $urandom_range(0, 7));
    end else if (r < 60) begin
      a[AW-1:0] = AW'($urandom_range(0, 255));
    end
    return a;
  endfunction

  // Stops offering beats until every expected result beat has arrived.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // One random command sequence: mostly well-formed, some cut short, some noise.
  task automatic run_sequence();
    int          pick;
    int          n;
    logic [23:0] a;
    logic [7:0]  cut_ops [3];
    cut_ops = '{OpRead, OpWrite, OpReadId};
    pick = $urandom_range(0, 99);
    n = ($urandom_range(0, 99) < 10) ? $urandom_range(7, 24) : $urandom_range(0, 6);
    a = pick_address();
    if (pick < 8) begin
      spi(OpWrEnable);
      repeat ($urandom_range(0, 2)) spi(8'($urandom));
      cs_release();
    end else if (pick < 14) begin
      spi(OpWrDisable);
      repeat ($urandom_range(0, 2)) spi(8'($urandom));
      cs_release();
    end else if (pick < 24) begin
      spi(OpReadStat);
      repeat (n) spi(8'($urandom));
      cs_release();
    end else if (pick < 34) begin
      spi(OpReadId);
      repeat (n) spi(8'($urandom));
      cs_release();
    end else if (pick < 52) begin
      spi(OpRead);
      send_address(a);
      repeat (n) spi(8'($urandom));
      cs_release();
    end else if (pick < 70) begin
      spi(OpWrite);
      send_address(a);
      repeat (n) spi(8'($urandom));
      cs_release();
    end else if (pick < 75) begin
      spi(OpProgram);
      repeat (n) spi(8'($urandom));
      cs_release();
    end else if (pick < 80) begin
      spi(8'($urandom));
      repeat (n) spi(8'($urandom));
      cs_release();
    end else if (pick < 88) begin
      repeat ($urandom_range(1, 4)) begin
        put_beat(KIND_LOAD, 8'($urandom), a[AW-1:0]);
        a = a + 24'd1;
      end
    end else if (pick < 94) begin
      // Released in the middle of the address or ID phase.
      spi(cut_ops[$urandom_range(0, 2)]);
      repeat ($urandom_range(0, 2)) spi(8'($urandom));
      cs_release();
    end else begin
      repeat ($urandom_range(1, 4)) put_beat(2'($urandom), 8'($urandom), AW'($urandom));
    end
  endtask

  // Result side: random stalls, one long hold-off, and a window without stalls.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && beats_sent >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (quiet_window()) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 15);
      end
    end
  end

  // Reset, directed beats, random sequences and the verdict.
  initial begin
    in_ch.valid        <= 1'b0;
    in_ch.command      <= KIND_SPI;
    in_ch.tx_byte      <= 8'h00;
    in_ch.load_address <= '0;
    rst_ni             <= 1'b0;
    beats_sent = 0;
    paused     = 1'b0;
    trk_sel    = 1'b0;
    trk_cmd    = 8'h00;
    trk_pos    = 3'd0;
    trk_addr   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A release while deselected, then the ignored kind.
    cs_release();
    put_beat(KindIgnored, 8'hFF, '1);
    // Write enable, then status read shows the latch.
    spi(OpWrEnable);
    cs_release();
    spi(OpReadStat);
    spi(8'h00);
    cs_release();
    // ID bytes run on into zeros once the position saturates.
    spi(OpReadId);
    repeat (4) spi(8'hFF);
    cs_release();
    // Write over the top of memory so that the address wraps, then read it back.
    spi(OpWrite);
    send_address(24'hFFFFFF);
    spi(8'h00);
    spi(8'hFF);
    cs_release();
    spi(OpRead);
    send_address(24'h03FFFF);
    spi(8'h00);
    spi(8'hFF);
    cs_release();
    // Program flushes on release; an unknown opcode answers the idle byte.
    spi(OpProgram);
    spi(8'h5A);
    cs_release();
    spi(8'h00);
    spi(8'hA5);
    cs_release();

    while (beats_sent < BeatTarget) begin
      if (!paused && beats_sent >= PauseAt) begin
        paused = 1'b1;
        drain_results();
      end
      run_sequence();
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
